@@ design/svmc_pkg.sv @@
// Shared types and constants for the state vector measure/collapse block.
// No dependencies; imported by the top level, the norm unit and the checker.
`default_nettype none

package svmc_pkg;

    // Fixed field widths of the stream and configuration channels
    localparam int INDEX_W    = 10;
    localparam int RAND_W     = 28;
    localparam int BITSEL_W   = 4;
    localparam int OUTCOME_W  = 10;
    localparam int M_TDATA_W  = 16;
    localparam int AMPS_W     = 11;
    localparam int TOL_W      = 29;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Norms are unsigned Q4.28; the remainder needs sign plus one guard bit
    localparam int FRAC_W = 28;
    localparam int NORM_W = 32;
    localparam int REM_W  = NORM_W + 2;

    // Command codes carried in s_tuser
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_MEASURE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMPS_IN_USE   = 2'd0,
        REG_NORM_TOLERANCE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic last;
    } norm_tag_t;

    typedef struct packed {
        norm_tag_t          tag;
        logic [NORM_W-1:0]  norm;
    } norm_beat_t;

endpackage

`default_nettype wire

@@ design/state_vector_measure_collapse_core.sv @@
// Top level of the state vector measure/collapse block.
// Depends on svmc_pkg, svmc_amp_ram and svmc_norm_unit.
`default_nettype none

// Holds up to MAX_AMPS complex amplitudes (Q2.(AMP_WIDTH-2) per part) in one
// on-chip RAM. A write beat (s_tuser = 0) stores one amplitude and returns
// nothing; writes may stream back to back. A measure beat
// (s_tuser = 1) walks the n = amps_in_use entries once through the RAM read
// port and a pipelined norm unit, summing norms for the validity check and
// subtracting them from random_value at the same time to find the outcome,
// then, if the state is valid and an outcome was found, rewrites the n
// entries through the write port (1.0 at the outcome, zero elsewhere).
// A count that is zero, not a power of two or above MAX_AMPS fails without
// reading the RAM. A finished measure holds while an earlier result still
// waits at the output. One result beat is returned per measure; the output
// register lets the next beat be taken while a result still waits. Entries
// must be written before they are measured: the RAM has no reset and no
// clearing pass. Write configuration only while the block is idle.
module state_vector_measure_collapse_core
    import svmc_pkg::*;
#(
    parameter int  MAX_AMPS  = 1024,
    parameter int  AMP_WIDTH = 16,
    localparam int S_TDATA_W =
        ((INDEX_W + 2 * AMP_WIDTH + RAND_W + BITSEL_W + 1 + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata fields, low bit up: index, amp_real, amp_imag, random_value,
    // bit_index, whole_state, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields: cmd
    input  wire logic                  s_tuser,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata fields, low bit up: outcome, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    // m_tuser fields: success
    output logic                       m_tuser,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W    = $clog2(MAX_AMPS);
    localparam int DATA_W    = 2 * AMP_WIDTH;
    localparam int SUM_W     = NORM_W + ADDR_W;
    localparam int OFF_RE    = INDEX_W;
    localparam int OFF_IM    = OFF_RE + AMP_WIDTH;
    localparam int OFF_RAND  = OFF_IM + AMP_WIDTH;
    localparam int OFF_BIT   = OFF_RAND + RAND_W;
    localparam int OFF_WHOLE = OFF_BIT + BITSEL_W;

    localparam logic [AMP_WIDTH-1:0] AMP_ONE = AMP_WIDTH'(1) << (AMP_WIDTH - 2);
    localparam logic [SUM_W-1:0]     SUM_ONE = SUM_W'(1) << FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_COLLAPSE,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [INDEX_W-1:0]          in_index;
    logic signed [AMP_WIDTH-1:0] in_re;
    logic signed [AMP_WIDTH-1:0] in_im;
    logic [RAND_W-1:0]           in_rand;
    logic [BITSEL_W-1:0]         in_bitsel;
    logic                        in_whole;

    assign in_index  = s_tdata[INDEX_W-1:0];
    assign in_re     = s_tdata[OFF_RE +: AMP_WIDTH];
    assign in_im     = s_tdata[OFF_IM +: AMP_WIDTH];
    assign in_rand   = s_tdata[OFF_RAND +: RAND_W];
    assign in_bitsel = s_tdata[OFF_BIT +: BITSEL_W];
    assign in_whole  = s_tdata[OFF_WHOLE];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                  state_reg;
    logic [AMPS_W-1:0]       amps_reg;
    logic [TOL_W-1:0]        tol_reg;
    logic                    iss_active_reg;
    logic [AMPS_W-1:0]       cnt_reg;
    norm_tag_t               rd_tag_reg;
    logic                    ok_reg;
    logic                    found_reg;
    logic                    m_tvalid_reg;
    logic                    success_reg;
    logic [OUTCOME_W-1:0]    outcome_reg;

    logic [AMPS_W-1:0]       rx_cnt_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic signed [REM_W-1:0] remain_reg;
    logic [AMPS_W-1:0]       pick_reg;
    logic [BITSEL_W-1:0]     bitsel_reg;
    logic                    whole_reg;

    // ------------------------------------------------------------------
    // Datapath signals
    // ------------------------------------------------------------------
    logic                    in_beat;
    logic                    count_ok;
    logic                    last_cnt;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [DATA_W-1:0]       wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       cnt_addr;
    logic [DATA_W-1:0]       rd_data;
    norm_tag_t               rd_tag;
    norm_beat_t              nbeat;
    logic signed [REM_W-1:0] rem_new;
    logic                    hit_now;
    logic [SUM_W-1:0]        diff;
    logic                    tol_ok;
    logic [AMPS_W-1:0]       pick_shift;
    logic [OUTCOME_W-1:0]    outcome_val;
    logic                    out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;

    // Count must be a nonzero power of two that fits the store
    assign count_ok = (amps_reg != '0)
                   && ((amps_reg & (amps_reg - AMPS_W'(1))) == '0)
                   && (32'(amps_reg) <= 32'(MAX_AMPS));

    assign last_cnt = (cnt_reg == amps_reg - AMPS_W'(1));
    assign cnt_addr = ADDR_W'(32'(cnt_reg));

    // Write port: amplitude writes while idle, collapse sweep otherwise
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_addr;
        wr_data = '0;
        if (in_beat && (s_tuser == CMD_WRITE) && (32'(in_index) < 32'(MAX_AMPS))) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(32'(in_index));
            wr_data = {in_im, in_re};
        end else if (state_reg == ST_COLLAPSE) begin
            wr_en   = 1'b1;
            wr_data = (cnt_reg == pick_reg) ? {{AMP_WIDTH{1'b0}}, AMP_ONE} : '0;
        end
    end

    assign rd_en      = (state_reg == ST_SCAN) && iss_active_reg;
    assign rd_tag     = rd_tag_reg;

    // Running remainder: first entry that drives it to zero or below wins
    assign rem_new = remain_reg - $signed({2'b00, nbeat.norm});
    assign hit_now = rem_new[REM_W-1] || (rem_new == '0);

    assign diff   = (sum_reg > SUM_ONE) ? (sum_reg - SUM_ONE) : (SUM_ONE - sum_reg);
    assign tol_ok = diff < SUM_W'(tol_reg);

    assign pick_shift  = pick_reg >> bitsel_reg;
    assign outcome_val = whole_reg ? pick_reg[OUTCOME_W-1:0]
                                   : {{(OUTCOME_W-1){1'b0}}, pick_shift[0]};
    assign out_free    = !m_tvalid_reg || m_tready;

    svmc_amp_ram #(
        .DEPTH  (MAX_AMPS),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_addr),
        .rd_data (rd_data)
    );

    svmc_norm_unit #(
        .AMP_WIDTH (AMP_WIDTH)
    ) u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (rd_tag),
        .in_re    (rd_data[AMP_WIDTH-1:0]),
        .in_im    (rd_data[DATA_W-1:AMP_WIDTH]),
        .out_beat (nbeat)
    );

    // ------------------------------------------------------------------
    // Sequencer: state, configuration and registered result
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            amps_reg       <= AMPS_W'(2);
            tol_reg        <= TOL_W'(2684);
            iss_active_reg <= 1'b0;
            cnt_reg        <= '0;
            rd_tag_reg     <= '0;
            ok_reg         <= 1'b0;
            found_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            success_reg    <= 1'b0;
            outcome_reg    <= '0;
        end else begin
            // Tag is registered so it travels alongside the registered read data
            rd_tag_reg.valid <= rd_en;
            rd_tag_reg.last  <= last_cnt;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_AMPS_IN_USE:    amps_reg <= cfg_data[AMPS_W-1:0];
                    REG_NORM_TOLERANCE: tol_reg  <= cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end

            // Drop the result once the sink takes it; a finishing measure
            // reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat && (s_tuser == CMD_MEASURE)) begin
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        if (count_ok) begin
                            iss_active_reg <= 1'b1;
                            state_reg      <= ST_SCAN;
                        end else begin
                            ok_reg    <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    // Issue reads until the last entry, then drain the pipeline
                    if (iss_active_reg) begin
                        cnt_reg <= cnt_reg + AMPS_W'(1);
                        if (last_cnt) begin
                            iss_active_reg <= 1'b0;
                        end
                    end
                    if (nbeat.tag.valid) begin
                        if (!found_reg && hit_now) begin
                            found_reg <= 1'b1;
                        end
                        if (nbeat.tag.last) begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    cnt_reg <= '0;
                    ok_reg  <= tol_ok && found_reg;
                    if (tol_ok && found_reg) begin
                        state_reg <= ST_COLLAPSE;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_COLLAPSE: begin
                    cnt_reg <= cnt_reg + AMPS_W'(1);
                    if (last_cnt) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        success_reg  <= ok_reg;
                        outcome_reg  <= ok_reg ? outcome_val : '0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Measure payload: norm sum, remainder and chosen index
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_beat && (s_tuser == CMD_MEASURE)) begin
            rx_cnt_reg <= '0;
            sum_reg    <= '0;
            remain_reg <= $signed({{(REM_W-RAND_W){1'b0}}, in_rand});
            bitsel_reg <= in_bitsel;
            whole_reg  <= in_whole;
        end else if ((state_reg == ST_SCAN) && nbeat.tag.valid) begin
            rx_cnt_reg <= rx_cnt_reg + AMPS_W'(1);
            sum_reg    <= sum_reg + SUM_W'(nbeat.norm);
            if (!found_reg) begin
                remain_reg <= rem_new;
                if (hit_now) begin
                    pick_reg <= rx_cnt_reg;
                end
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = success_reg;
    assign m_tdata  = {{(M_TDATA_W-OUTCOME_W){1'b0}}, outcome_reg};

endmodule

`default_nettype wire

@@ design/svmc_amp_ram.sv @@
// Simple dual-port amplitude memory: one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none

module svmc_amp_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/svmc_norm_unit.sv @@
// Two-stage norm pipeline: squares of both parts, then sum scaled to Q4.28.
// Depends on svmc_pkg for the beat types and norm width.
`default_nettype none

module svmc_norm_unit
    import svmc_pkg::*;
#(
    parameter int AMP_WIDTH = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire norm_tag_t                   in_tag,
    input  wire logic signed [AMP_WIDTH-1:0] in_re,
    input  wire logic signed [AMP_WIDTH-1:0] in_im,
    output norm_beat_t                       out_beat
);

    localparam int SQ_W      = 2 * AMP_WIDTH;
    localparam int PROD_FRAC = 2 * (AMP_WIDTH - 2);
    localparam int SHR       = (PROD_FRAC >= FRAC_W) ? PROD_FRAC - FRAC_W : 0;
    localparam int SHL       = (PROD_FRAC <  FRAC_W) ? FRAC_W - PROD_FRAC : 0;

    logic [AMP_WIDTH-1:0]   mag_re;
    logic [AMP_WIDTH-1:0]   mag_im;
    norm_tag_t              tag_a_reg;
    norm_tag_t              tag_b_reg;
    logic [SQ_W-1:0]        sq_re_reg;
    logic [SQ_W-1:0]        sq_im_reg;
    logic [SQ_W-1:0]        sq_sum;
    logic [SQ_W+NORM_W-1:0] sq_ext;
    logic [SQ_W+NORM_W-1:0] scaled;
    logic [NORM_W-1:0]      norm_reg;

    // Magnitude of the most negative code is exactly representable unsigned
    assign mag_re = in_re[AMP_WIDTH-1] ? (~in_re + 1'b1) : in_re;
    assign mag_im = in_im[AMP_WIDTH-1] ? (~in_im + 1'b1) : in_im;

    // Each square is at most 2^(2W-2), so their sum cannot carry out
    assign sq_sum = sq_re_reg + sq_im_reg;
    assign sq_ext = {{NORM_W{1'b0}}, sq_sum};
    assign scaled = (sq_ext >> SHR) << SHL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end else begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sq_re_reg <= mag_re * mag_re;
        sq_im_reg <= mag_im * mag_im;
        norm_reg  <= scaled[NORM_W-1:0];
    end

    assign out_beat = {tag_b_reg, norm_reg};

endmodule

`default_nettype wire

@@ design/svmc_checker.sv @@
// Port-level checker for the state vector measure/collapse block, with bind.
// Depends on svmc_pkg for command codes and result widths.
`default_nettype none

module svmc_checker
    import svmc_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tuser
);

    // A stalled result beat holds its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A failed measure reports a zero outcome
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed measure with nonzero outcome");

    // An amplitude write leaves the block ready in the next cycle
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_WRITE) |=> s_tready)
        else $error("block not ready after a write beat");

    // A measure beat occupies the block for at least the next cycle
    a_measure_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == CMD_MEASURE) |=> !s_tready)
        else $error("block ready right after a measure beat");

endmodule

bind state_vector_measure_collapse_core svmc_checker u_svmc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/state_vector_measure_collapse_core_test.sv @@
// Self-checking testbench for state_vector_measure_collapse_core.
// Streams amplitude writes and measures, predicts every result beat in-line and
// compares it with the output. Depends on svmc_pkg and the RTL only.
module state_vector_measure_collapse_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import svmc_pkg::*;

    localparam int     MAX_N        = 1024;
    localparam int     AMP_W        = 16;
    localparam int     S_W          =
        ((INDEX_W + 2 * AMP_W + RAND_W + BITSEL_W + 1 + 7) / 8) * 8;
    localparam longint ONE_Q28      = longint'(1) << FRAC_W;
    localparam longint RND_TOP      = ONE_Q28 - 1;
    localparam int     AMPS_RESET   = 2;
    localparam int     TOL_RESET    = 2684;
    localparam int     BIG_N        = 128;
    localparam int     RANDOM_ITEMS = 100;
    localparam int     IDLE_LIMIT   = 20000;
    // A successful measure walks the store twice; wait that long before config
    localparam int     SETTLE_CYCLES = 2 * MAX_N + 16;
    localparam int     REPORT_CAP    = 10;

    // Register indexes past the end of the list; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_t;

    typedef struct {
        logic                    cmd;
        logic [INDEX_W-1:0]      index;
        logic signed [AMP_W-1:0] re;
        logic signed [AMP_W-1:0] im;
        logic [RAND_W-1:0]       rnd;
        logic [BITSEL_W-1:0]     bitsel;
        logic                    whole;
    } amp_op_t;

    typedef struct {
        logic                 success;
        logic [OUTCOME_W-1:0] outcome;
    } measure_result_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // Input stream
    logic           s_tvalid = 1'b0;
    wire            s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tuser  = CMD_WRITE;

    // Result stream
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire [M_TDATA_W-1:0] m_tdata;
    wire                 m_tuser;

    // Configuration channel
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_AMPS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Beats waiting for the driver, and outcomes waiting for the output
    amp_op_t         pending_ops[$];
    measure_result_t expected_outcomes[$];

    // Shadow copy of the amplitude store and the registers
    logic signed [AMP_W-1:0] shadow_re[MAX_N];
    logic signed [AMP_W-1:0] shadow_im[MAX_N];
    logic [AMPS_W-1:0]       shadow_amps = AMPS_RESET;
    logic [TOL_W-1:0]        shadow_tol  = TOL_RESET;

    // Running norm sums of the last loaded state, for boundary random values
    longint load_prefix[$];

    int  queued_items = 0;
    bit  settled      = 1'b1;
    int  errors       = 0;
    int  n_writes     = 0;
    int  n_measures   = 0;
    int  n_collapses  = 0;
    int  n_cfg        = 0;
    int  quiet_cycles = 0;

    // Driver and receiver state
    amp_op_t  drv_op;
    bit       in_taken   = 1'b0;
    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       rx_phase   = 0;
    measure_result_t want;

    state_vector_measure_collapse_core #(
        .MAX_AMPS  (MAX_N),
        .AMP_WIDTH (AMP_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Norm of one entry: Q2.14 squared is already Q4.28, so no rescaling
    function automatic longint amp_norm(logic signed [AMP_W-1:0] re,
                                        logic signed [AMP_W-1:0] im);
        longint r;
        longint m;
        r = re;
        m = im;
        if (r < 0) r = -r;
        if (m < 0) m = -m;
        return r * r + m * m;
    endfunction

    // Apply one accepted beat to the shadow store; a measure queues its outcome
    function automatic void step_state_vector(amp_op_t op);
        measure_result_t res;
        longint          total;
        longint          diff;
        longint          remain;
        int              n;
        int              i;
        int              k;
        res.success = 1'b0;
        res.outcome = '0;
        if (op.cmd == CMD_WRITE) begin
            shadow_re[op.index] = op.re;
            shadow_im[op.index] = op.im;
            return;
        end
        n = shadow_amps;
        // Bad count: fail without touching the store
        if (n == 0 || n > MAX_N || (n & (n - 1)) != 0) begin
            expected_outcomes.push_back(res);
            return;
        end
        total = 0;
        for (i = 0; i < n; i++) total += amp_norm(shadow_re[i], shadow_im[i]);
        diff = (total > ONE_Q28) ? total - ONE_Q28 : ONE_Q28 - total;
        if (diff < longint'(shadow_tol)) begin
            remain = longint'(op.rnd);
            for (i = 0; i < n; i++) begin
                remain -= amp_norm(shadow_re[i], shadow_im[i]);
                if (remain <= 0) begin
                    // Collapse: 1.0 at the outcome, zero over the rest in use
                    for (k = 0; k < n; k++) begin
                        shadow_re[k] = '0;
                        shadow_im[k] = '0;
                    end
                    shadow_re[i] = AMP_W'(1 << (AMP_W - 2));
                    res.success  = 1'b1;
                    res.outcome  = op.whole ? OUTCOME_W'(i)
                                            : OUTCOME_W'((i >> op.bitsel) & 1);
                    break;
                end
            end
        end
        expected_outcomes.push_back(res);
    endfunction

    function automatic logic [S_W-1:0] pack_op(amp_op_t op);
        return S_W'({op.whole, op.bitsel, op.rnd, op.im, op.re, op.index});
    endfunction

    function automatic longint isqrt(longint x);
        longint r;
        longint t;
        int     b;
        r = 0;
        for (b = 16; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Unused fields of a write carry random bits so every bit toggles
    function automatic void queue_write(int idx, int re, int im);
        amp_op_t op;
        op.cmd    = CMD_WRITE;
        op.index  = INDEX_W'(idx);
        op.re     = AMP_W'(re);
        op.im     = AMP_W'(im);
        op.rnd    = RAND_W'($urandom);
        op.bitsel = BITSEL_W'($urandom);
        op.whole  = 1'($urandom);
        pending_ops.push_back(op);
        queued_items++;
        settled = 1'b0;
    endfunction

    function automatic void queue_measure(longint rnd, int bitsel, int whole);
        amp_op_t op;
        op.cmd    = CMD_MEASURE;
        op.index  = INDEX_W'($urandom);
        op.re     = AMP_W'($urandom);
        op.im     = AMP_W'($urandom);
        op.rnd    = RAND_W'(rnd);
        op.bitsel = BITSEL_W'(bitsel);
        op.whole  = 1'(whole);
        pending_ops.push_back(op);
        queued_items++;
        settled = 1'b0;
    endfunction

    // Random value: mostly uniform, sometimes the ends or a prefix-sum boundary
    function automatic void queue_random_measure();
        longint rnd;
        int     k;
        case ($urandom_range(0, 9))
            0: rnd = 0;
            1: rnd = RND_TOP;
            2, 3: begin
                if (load_prefix.size() > 0) begin
                    k   = $urandom_range(0, load_prefix.size() - 1);
                    rnd = load_prefix[k] + $urandom_range(0, 1);
                    if (rnd > RND_TOP) rnd = RND_TOP;
                end else begin
                    rnd = $urandom_range(0, RND_TOP);
                end
            end
            default: rnd = $urandom_range(0, RND_TOP);
        endcase
        queue_measure(rnd, $urandom_range(0, 15), $urandom_range(0, 1));
    endfunction

    // Write n entries whose norms add up to 1.0 less the square-root truncation;
    // the last entry takes up the truncation slack of the others
    function automatic void load_unit_state(int n);
        longint weight[$];
        longint total;
        longint used;
        longint target;
        longint re_m;
        longint im_m;
        int     k;
        total = 0;
        used  = 0;
        load_prefix.delete();
        for (k = 0; k < n; k++) begin
            weight.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255));
            total += weight[k];
        end
        if (total == 0) begin
            weight[0] = 1;
            total     = 1;
        end
        for (k = 0; k < n; k++) begin
            target = (k == n - 1) ? ONE_Q28 - used : (ONE_Q28 * weight[k]) / total;
            re_m   = isqrt(target * $urandom_range(0, 16) / 16);
            im_m   = isqrt(target - re_m * re_m);
            used  += re_m * re_m + im_m * im_m;
            load_prefix.push_back(used);
            queue_write(k, int'($urandom_range(0, 1) ? -re_m : re_m),
                        int'($urandom_range(0, 1) ? -im_m : im_m));
        end
    endfunction

    // Hold until every queued beat is taken and every outcome has come back;
    // with settle, also let a trailing measure or collapse run out
    task automatic drain(bit settle);
        while (pending_ops.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
            @(posedge aclk);
        if (settle && !settled) begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            settled = 1'b1;
        end
    endtask

    // Registers are only written with the block idle
    task automatic write_cfg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        drain(1'b1);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (addr == REG_AMPS_IN_USE)
            shadow_amps = value[AMPS_W-1:0];
        else if (addr == REG_NORM_TOLERANCE)
            shadow_tol = value[TOL_W-1:0];
        n_cfg++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sender: bursts of random length separated by random gaps; hold a beat
    // until it is taken, then advance to the next one in the queue
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
                drv_op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= drv_op.cmd;
                s_tdata  <= pack_op(drv_op);
                burst_left--;
                if (burst_left <= 0) begin
                    case ($urandom_range(0, 7))
                        0: begin
                            // long stretch with no idling
                            burst_left = $urandom_range(30, 60);
                            gap_left   = 0;
                        end
                        1: begin
                            burst_left = $urandom_range(1, 10);
                            gap_left   = $urandom_range(15, 40);
                        end
                        default: begin
                            burst_left = $urandom_range(1, 10);
                            gap_left   = $urandom_range(0, 6);
                        end
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switch at random between stall patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(24, 96);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RX_PATTERN: m_tready <= (rx_phase % 5) >= 2;
            default:    m_tready <= (rx_phase % 16) == 0;
        endcase
    end

    // Monitor: check result beats first, then predict from the input beat
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                if (errors < REPORT_CAP)
                    $display("%0t: unexpected result beat success=%0d outcome=%0d",
                             $realtime, m_tuser, m_tdata[OUTCOME_W-1:0]);
                errors++;
            end else begin
                want = expected_outcomes.pop_front();
                if (m_tuser !== want.success || m_tdata[OUTCOME_W-1:0] !== want.outcome)
                begin
                    if (errors < REPORT_CAP)
                        $display({"%0t: result mismatch, expected success=%0d ",
                                  "outcome=%0d, got success=%0d outcome=%0d"},
                                 $realtime, want.success, want.outcome,
                                 m_tuser, m_tdata[OUTCOME_W-1:0]);
                    errors++;
                end
                if (want.success) n_collapses++;
            end
        end
        if (in_taken) begin
            step_state_vector(drv_op);
            if (drv_op.cmd == CMD_WRITE) n_writes++;
            else n_measures++;
        end
    end

    // Watchdog: count cycles in which no beat moves on any channel
    always @(posedge aclk) begin
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                        (cfg_valid && cfg_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("state_vector_measure_collapse_core test failed");
            $finish;
        end
    end

    initial begin
        int     random_start;
        int     phase_start;
        int     budget;
        int     n;
        int     pick;
        longint tol;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset register values (two entries, tolerance 2684)
        // Extreme parts: norm sum far above 1.0, must fail
        queue_write(0, 32767, -32768);
        queue_write(1, -32768, 32767);
        queue_measure($urandom_range(0, RND_TOP), $urandom_range(0, 15), 1);
        // 1.0 at entry 0: zero and top random values both land on entry 0
        queue_write(0, 16384, 0);
        queue_write(1, 0, 0);
        queue_measure(0, 0, 1);
        queue_measure(RND_TOP, 9, 0);
        // Negative imaginary 1.0 at entry 1; report whole, bit 0, bit past top
        queue_write(0, 0, 0);
        queue_write(1, 0, -16384);
        queue_measure(RND_TOP, 0, 1);
        queue_measure(1, 0, 0);
        queue_measure(5, 15, 0);
        // Sum just below 1.0: top random value is never used up; then a value
        // that brings the remainder exactly to zero at entry 1
        queue_write(0, 16383, 0);
        queue_write(1, 0, -181);
        queue_measure(RND_TOP, 0, 1);
        queue_measure(268435450, 0, 1);

        // Single entry in use: zero norm fails, then 1.0 succeeds
        write_cfg(REG_AMPS_IN_USE, 1);
        queue_measure(RND_TOP, 0, 1);
        queue_write(0, 0, 16384);
        queue_measure(RND_TOP, 0, 1);

        // Bad counts fail at once; spare indexes change nothing
        write_cfg(REG_AMPS_IN_USE, 0);
        queue_measure(RND_TOP, 0, 1);
        write_cfg(REG_AMPS_IN_USE, 3);
        queue_measure(RND_TOP, 0, 1);
        write_cfg(REG_AMPS_IN_USE, (1 << AMPS_W) - 1);
        queue_measure(RND_TOP, 0, 1);
        write_cfg(REG_SPARE_A, $urandom);
        write_cfg(REG_SPARE_B, $urandom);
        queue_measure(RND_TOP, 0, 1);

        // Tolerance extremes: zero rejects everything, all-ones accepts
        write_cfg(REG_AMPS_IN_USE, 2);
        write_cfg(REG_NORM_TOLERANCE, 0);
        queue_measure($urandom_range(0, RND_TOP), 0, 1);
        write_cfg(REG_NORM_TOLERANCE, (1 << TOL_W) - 1);
        queue_measure($urandom_range(0, RND_TOP), $urandom_range(0, 15), 0);

        // One larger store: every entry in use gets written, then collapsed
        write_cfg(REG_AMPS_IN_USE, BIG_N);
        write_cfg(REG_NORM_TOLERANCE, TOL_RESET);
        load_unit_state(BIG_N);
        repeat (3) queue_random_measure();

        // Random phases on small stores: mostly normalized states followed by
        // measures, some corrupting writes, some repeat measures of a collapse
        random_start = queued_items;
        while (queued_items - random_start < RANDOM_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                             : (1 << $urandom_range(0, 5));
            case ($urandom_range(0, 5))
                0: tol = TOL_RESET;
                1: tol = 1;
                2: tol = 512;
                3: tol = 1 << 16;
                4: tol = ONE_Q28;
                default: tol = $urandom_range(0, 1 << 20);
            endcase
            write_cfg(REG_AMPS_IN_USE, n);
            if ($urandom_range(0, 3) != 0) write_cfg(REG_NORM_TOLERANCE, CFG_DATA_W'(tol));
            load_unit_state(n);
            queue_random_measure();
            phase_start = queued_items;
            budget      = $urandom_range(15, 40);
            while (queued_items - phase_start < budget) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    load_unit_state(n);
                    repeat ($urandom_range(1, 3)) queue_random_measure();
                end else if (pick < 9) begin
                    repeat ($urandom_range(1, 4))
                        queue_write(($urandom_range(0, 1) != 0) ? $urandom_range(0, n - 1)
                                                                : $urandom_range(0, MAX_N - 1),
                                    $urandom, $urandom);
                    queue_random_measure();
                end else begin
                    queue_random_measure();
                end
                // Now and then hold the sender until the output has caught up
                if ($urandom_range(0, 7) == 0) drain(1'b0);
            end
        end

        drain(1'b1);
        $display("covered %0d amplitude writes, %0d measures (%0d collapsed), %0d register writes",
                 n_writes, n_measures, n_collapses, n_cfg);
        if (errors != 0) $display("%0d result errors", errors);
        if (errors == 0)
            $display("state_vector_measure_collapse_core test passed");
        else
            $display("state_vector_measure_collapse_core test failed");
        $finish;
    end

endmodule
